// ===== rtl/core/rsmg_pkg.sv =====
// shared types, widths, register codes and tables of the ring sector mesh generator
package rsmg_pkg;

   localparam int MAX_SEGMENTS_DEF  = 4096;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ATAN_LEN          = 24;

   // field widths
   localparam int RAD_W      = 16;
   localparam int CNT_W      = 13;
   localparam int ANGLE_W    = 16;
   localparam int COLOR_W    = 32;
   localparam int VTX_W      = 24;
   localparam int SEG_W      = 12;
   localparam int POS_W      = 17;
   localparam int TEX_W      = 17;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   // datapath widths
   localparam int IDX_W      = 13;                 // segment index plus one
   localparam int DEN_W      = CNT_W + 1;          // twice the segment count
   localparam int MUL_W      = IDX_W + RAD_W;      // index times angle span
   localparam int ANG_SHIFT  = 18;                 // Q4.12 to Q4.30
   localparam int DIV_W      = MUL_W + ANG_SHIFT + 2;
   localparam int QA_W       = 35;
   localparam int ANG_W      = 37;
   localparam int CZ_W       = 33;
   localparam int PROD_W     = CZ_W + RAD_W + 1;

   localparam logic signed [CZ_W-1:0]   GAIN_Q30    = 33'sd652032874;
   localparam logic signed [ANG_W-1:0]  PI_Q30      = 37'sd3373259426;
   localparam logic signed [ANG_W-1:0]  HALF_PI_Q30 = 37'sd1686629713;
   localparam logic signed [ANG_W-1:0]  TWO_PI_Q30  = 37'sd6746518852;
   localparam logic signed [PROD_W-1:0] ROUND_BIAS  = 50'sd536870912;
   localparam logic signed [PROD_W-1:0] POS_MAX     = 50'sd65535;
   localparam logic signed [PROD_W-1:0] POS_MIN     = -50'sd65536;
   localparam logic [TEX_W-1:0]         TEX_V_INNER = 17'd65536;

   localparam logic KIND_VERTEX   = 1'b0;
   localparam logic KIND_TRIANGLE = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_INNER_RADIUS  = 8'd0,
      REG_OUTER_RADIUS  = 8'd1,
      REG_SEGMENT_COUNT = 8'd2,
      REG_START_ANGLE   = 8'd3,
      REG_END_ANGLE     = 8'd4,
      REG_INNER_COLOR   = 8'd5,
      REG_OUTER_COLOR   = 8'd6,
      REG_BASE_VERTEX   = 8'd7
   } csr_reg_type;

   // per-angle sideband that rides along the cells
   typedef struct packed {
      logic              j;
      logic [TEX_W-1:0]  ratio;
      logic [VTX_W-1:0]  base;
   } info_type;

   typedef struct packed {
      logic [DEN_W-1:0] rem_a;
      logic [DIV_W-1:0] dvd_a;
      logic [DEN_W-1:0] rem_r;
      logic [DIV_W-1:0] dvd_r;
      info_type         info;
   } div_type;

   typedef struct packed {
      logic signed [CZ_W-1:0] x;
      logic signed [CZ_W-1:0] y;
      logic signed [CZ_W-1:0] z;
      logic                   flip;
      info_type               info;
   } cordic_type;

   typedef struct packed {
      logic signed [POS_W-1:0] ox;
      logic signed [POS_W-1:0] oy;
      logic signed [POS_W-1:0] ix;
      logic signed [POS_W-1:0] iy;
   } pos_set_type;

   function automatic logic [30:0] atan_q30(input int k);
      case (k)
         0:       atan_q30 = 31'h3243F6A8;
         1:       atan_q30 = 31'h1DAC6705;
         2:       atan_q30 = 31'h0FADBAFC;
         3:       atan_q30 = 31'h07F56EA6;
         4:       atan_q30 = 31'h03FEAB76;
         5:       atan_q30 = 31'h01FFD55B;
         6:       atan_q30 = 31'h00FFFAAA;
         7:       atan_q30 = 31'h007FFF55;
         8:       atan_q30 = 31'h003FFFEA;
         9:       atan_q30 = 31'h001FFFFD;
         10:      atan_q30 = 31'h000FFFFF;
         11:      atan_q30 = 31'h0007FFFF;
         12:      atan_q30 = 31'h0003FFFF;
         13:      atan_q30 = 31'h0001FFFF;
         14:      atan_q30 = 31'h0000FFFF;
         15:      atan_q30 = 31'h00007FFF;
         16:      atan_q30 = 31'h00003FFF;
         17:      atan_q30 = 31'h00001FFF;
         18:      atan_q30 = 31'h00000FFF;
         19:      atan_q30 = 31'h000007FF;
         20:      atan_q30 = 31'h000003FF;
         21:      atan_q30 = 31'h000001FF;
         22:      atan_q30 = 31'h000000FF;
         23:      atan_q30 = 31'h0000007F;
         default: atan_q30 = 31'h00000000;
      endcase
   endfunction

endpackage

// ===== rtl/core/rsmg_ifs.sv =====
// request, response and register write channel interfaces
interface rsmg_req_if;
   import rsmg_pkg::*;
   logic             valid;
   logic             ready;
   logic [SEG_W-1:0] segment_index;
   modport source(output valid, segment_index, input ready);
   modport sink(input valid, segment_index, output ready);
endinterface

interface rsmg_rsp_if;
   import rsmg_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    record_kind;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic [TEX_W-1:0]        tex_u;
   logic [TEX_W-1:0]        tex_v;
   logic [COLOR_W-1:0]      vertex_color;
   logic [VTX_W-1:0]        tri_first;
   logic [VTX_W-1:0]        tri_second;
   logic [VTX_W-1:0]        tri_third;
   logic                    last_of_segment;
   modport source(output valid, record_kind, pos_x, pos_y, tex_u, tex_v, vertex_color,
                  tri_first, tri_second, tri_third, last_of_segment, input ready);
   modport sink(input valid, record_kind, pos_x, pos_y, tex_u, tex_v, vertex_color,
                tri_first, tri_second, tri_third, last_of_segment, output ready);
endinterface

interface rsmg_csr_if;
   import rsmg_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/rsmg_div_cell.sv =====
// one restoring division step for the ratio and angle quotients
module rsmg_div_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic [rsmg_pkg::DEN_W-1:0]      den,
   input  logic                            in_valid,
   input  rsmg_pkg::div_type               in_data,
   output logic                            out_valid,
   output rsmg_pkg::div_type               out_data
);
   import rsmg_pkg::*;

   logic          valid_ff;
   div_type       data_ff;
   div_type       data_in;
   logic [DEN_W:0] trial_a;
   logic [DEN_W:0] trial_r;
   logic          ge_a;
   logic          ge_r;

   always_comb begin
      trial_a = {in_data.rem_a, in_data.dvd_a[DIV_W-1]};
      trial_r = {in_data.rem_r, in_data.dvd_r[DIV_W-1]};
      ge_a    = trial_a >= {1'b0, den};
      ge_r    = trial_r >= {1'b0, den};
      data_in = in_data;
      data_in.rem_a = ge_a ? DEN_W'(trial_a - {1'b0, den}) : trial_a[DEN_W-1:0];
      data_in.rem_r = ge_r ? DEN_W'(trial_r - {1'b0, den}) : trial_r[DEN_W-1:0];
      data_in.dvd_a = {in_data.dvd_a[DIV_W-2:0], ge_a};
      data_in.dvd_r = {in_data.dvd_r[DIV_W-2:0], ge_r};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/core/rsmg_cordic_cell.sv =====
// one cordic rotation step with a fixed shift and arctangent
module rsmg_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  rsmg_pkg::cordic_type  in_data,
   output logic                  out_valid,
   output rsmg_pkg::cordic_type  out_data
);
   import rsmg_pkg::*;

   localparam logic signed [CZ_W-1:0] ATAN = $signed(CZ_W'(atan_q30(STAGE)));

   logic                   valid_ff;
   cordic_type             data_ff;
   cordic_type             data_in;
   logic signed [CZ_W-1:0] xs;
   logic signed [CZ_W-1:0] ys;

   always_comb begin
      xs      = in_data.x >>> STAGE;
      ys      = in_data.y >>> STAGE;
      data_in = in_data;
      if (!in_data.z[CZ_W-1]) begin
         data_in.x = in_data.x - ys;
         data_in.y = in_data.y + xs;
         data_in.z = in_data.z - ATAN;
      end else begin
         data_in.x = in_data.x + ys;
         data_in.y = in_data.y - xs;
         data_in.z = in_data.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/core/ring_sector_mesh_generator.sv =====
// top level of the ring sector mesh generator: registers, cell chains and record emitter
//
// usage
//   csr_ch: register writes (index, data); always ready, taken on valid. write only while
//     idle. indexes beyond base_vertex are dropped
//   req_ch: one word per segment, carrying segment_index
//   rsp_ch: six words per segment, in order outer current, outer next, inner current,
//     inner next, then two triangles; last_of_segment marks the sixth
// timing
//   each segment is split into two angle jobs that walk a chain of DIV_W = 49 divider
//   cells (one quotient bit per cell) and CORDIC_STAGES rotation cells, then two scaling
//   stages. sustained rate is set by the response channel moving one word per cycle
//   while rsp_ch.ready is high; a request can be taken in any cycle the front job slot
//   is free
// reset
//   synchronous; empties all cells and buffers and loads register defaults
// stalls
//   while rsp_ch is held the emitter keeps its word, the whole chain freezes once the
//   second job of the next segment reaches the end, and req_ch.ready falls after that
module ring_sector_mesh_generator #(
   parameter int MAX_SEGMENTS  = rsmg_pkg::MAX_SEGMENTS_DEF,
   parameter int CORDIC_STAGES = rsmg_pkg::CORDIC_STAGES_DEF
) (
   input  logic           clock,
   input  logic           reset,
   rsmg_req_if.sink       req_ch,
   rsmg_rsp_if.source     rsp_ch,
   rsmg_csr_if.sink       csr_ch
);
   import rsmg_pkg::*;

   typedef enum logic [5:0] {
      REC_OUT0 = 6'b000001,
      REC_OUT1 = 6'b000010,
      REC_IN0  = 6'b000100,
      REC_IN1  = 6'b001000,
      REC_TRI0 = 6'b010000,
      REC_TRI1 = 6'b100000
   } rec_state_type;

   // ---------------- configuration registers ----------------
   logic [RAD_W-1:0]          inner_radius_ff;
   logic [RAD_W-1:0]          outer_radius_ff;
   logic [CNT_W-1:0]          segment_count_ff;
   logic signed [ANGLE_W-1:0] start_angle_ff;
   logic signed [ANGLE_W-1:0] end_angle_ff;
   logic [COLOR_W-1:0]        inner_color_ff;
   logic [COLOR_W-1:0]        outer_color_ff;
   logic [VTX_W-1:0]          base_vertex_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_radius_ff  <= 16'd128;
         outer_radius_ff  <= 16'd256;
         segment_count_ff <= 13'd32;
         start_angle_ff   <= 16'sd0;
         end_angle_ff     <= 16'sd25736;
         inner_color_ff   <= 32'hFFFF_FFFF;
         outer_color_ff   <= 32'hFFFF_FFFF;
         base_vertex_ff   <= 24'd0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            REG_INNER_RADIUS:  inner_radius_ff  <= csr_ch.data[RAD_W-1:0];
            REG_OUTER_RADIUS:  outer_radius_ff  <= csr_ch.data[RAD_W-1:0];
            REG_SEGMENT_COUNT: segment_count_ff <= csr_ch.data[CNT_W-1:0];
            REG_START_ANGLE:   start_angle_ff   <= $signed(csr_ch.data[ANGLE_W-1:0]);
            REG_END_ANGLE:     end_angle_ff     <= $signed(csr_ch.data[ANGLE_W-1:0]);
            REG_INNER_COLOR:   inner_color_ff   <= csr_ch.data[COLOR_W-1:0];
            REG_OUTER_COLOR:   outer_color_ff   <= csr_ch.data[COLOR_W-1:0];
            REG_BASE_VERTEX:   base_vertex_ff   <= csr_ch.data[VTX_W-1:0];
            default: ;
         endcase
      end
   end

   // derived values; the user must keep them stable while any segment is in flight, the block does not enforce it
   logic [CNT_W-1:0]            count_min1;
   logic [CNT_W-1:0]            n_eff;
   logic [DEN_W-1:0]            den;
   logic signed [ANGLE_W:0]     angle_span;
   logic                        span_neg;
   logic [RAD_W-1:0]            span_abs;
   logic signed [ANG_W-1:0]     start_ext;

   always_comb begin
      count_min1 = (segment_count_ff == '0) ? CNT_W'(1) : segment_count_ff;
      n_eff      = (32'(count_min1) > 32'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS) : count_min1;
      den        = {n_eff, 1'b0};
      angle_span = (ANGLE_W+1)'(end_angle_ff) - (ANGLE_W+1)'(start_angle_ff);
      span_neg   = angle_span[ANGLE_W];
      span_abs   = span_neg ? RAD_W'(-angle_span) : RAD_W'(angle_span);
      start_ext  = ANG_W'(start_angle_ff);
   end

   // pipeline advance, shared by all stages; it only falls when the emitter is full
   logic adv;

   // ---------------- request hold and job issue ----------------
   logic             hold_valid_ff;
   logic             hold_j_ff;
   logic [IDX_W-1:0] hold_idx_ff;
   logic [VTX_W-1:0] hold_base_ff;
   logic [IDX_W-1:0] idx_sat;
   logic             req_take;

   always_comb begin
      idx_sat = ({1'b0, req_ch.segment_index} >= n_eff) ?
                IDX_W'(n_eff - CNT_W'(1)) : {1'b0, req_ch.segment_index};
   end

   assign req_ch.ready = !hold_valid_ff || (adv && hold_j_ff);
   assign req_take     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         hold_j_ff     <= 1'b0;
      end else if (req_take) begin
         hold_valid_ff <= 1'b1;
         hold_j_ff     <= 1'b0;
      end else if (adv && hold_valid_ff) begin
         hold_j_ff     <= !hold_j_ff;
         hold_valid_ff <= !hold_j_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         hold_idx_ff  <= idx_sat;
         hold_base_ff <= base_vertex_ff + VTX_W'({idx_sat, 2'b00});
      end
   end

   // ---------------- prep: index times span ----------------
   logic             p0_valid_ff;
   logic [MUL_W-1:0] p0_prod_ff;
   logic [IDX_W-1:0] p0_idx_ff;
   info_type         p0_info_ff;
   logic [IDX_W-1:0] issue_idx;

   assign issue_idx = hold_idx_ff + IDX_W'(hold_j_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
      end else if (adv) begin
         p0_valid_ff <= hold_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_prod_ff       <= MUL_W'(issue_idx) * MUL_W'(span_abs);
         p0_idx_ff        <= issue_idx;
         p0_info_ff.j     <= hold_j_ff;
         p0_info_ff.ratio <= '0;
         p0_info_ff.base  <= hold_base_ff;
      end
   end

   // ---------------- divider cell chain ----------------
   logic    div_v [0:DIV_W];
   div_type div_d [0:DIV_W];

   // a negative span uses the floor identity -floor((p + n - 1) / 2n)
   always_comb begin
      div_v[0]       = p0_valid_ff;
      div_d[0].rem_a = '0;
      div_d[0].rem_r = '0;
      div_d[0].dvd_a = DIV_W'({p0_prod_ff, {(ANG_SHIFT+1){1'b0}}}) + DIV_W'(n_eff)
                       - DIV_W'(span_neg);
      div_d[0].dvd_r = DIV_W'({p0_idx_ff, {(TEX_W){1'b0}}}) + DIV_W'(n_eff);
      div_d[0].info  = p0_info_ff;
   end

   for (genvar g = 0; g < DIV_W; g++) begin : g_div
      rsmg_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .den       (den),
         .in_valid  (div_v[g]),
         .in_data   (div_d[g]),
         .out_valid (div_v[g+1]),
         .out_data  (div_d[g+1])
      );
   end

   // ---------------- angle assembly ----------------
   logic                    ps1_valid_ff;
   logic signed [ANG_W-1:0] ps1_ang_ff;
   info_type                ps1_info_ff;
   info_type                ps1_info_in;
   logic signed [ANG_W-1:0] quot_ext;

   assign quot_ext = $signed(ANG_W'(div_d[DIV_W].dvd_a[QA_W-1:0]));

   // ratio quotient joins the sideband here
   always_comb begin
      ps1_info_in       = div_d[DIV_W].info;
      ps1_info_in.ratio = div_d[DIV_W].dvd_r[TEX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ps1_valid_ff <= 1'b0;
      end else if (adv) begin
         ps1_valid_ff <= div_v[DIV_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ps1_ang_ff  <= (start_ext <<< ANG_SHIFT) + (span_neg ? -quot_ext : quot_ext);
         ps1_info_ff <= ps1_info_in;
      end
   end

   // ---------------- range reduction ----------------
   logic                    ps2_valid_ff;
   cordic_type              ps2_data_ff;
   logic signed [ANG_W-1:0] turn_red;
   logic signed [ANG_W-1:0] half_red;
   logic                    flip;

   // the angle lies between start and end, so one whole turn is enough
   always_comb begin
      if (ps1_ang_ff > PI_Q30) begin
         turn_red = ps1_ang_ff - TWO_PI_Q30;
      end else if (ps1_ang_ff < -PI_Q30) begin
         turn_red = ps1_ang_ff + TWO_PI_Q30;
      end else begin
         turn_red = ps1_ang_ff;
      end
      flip = 1'b1;
      if (turn_red > HALF_PI_Q30) begin
         half_red = turn_red - PI_Q30;
      end else if (turn_red < -HALF_PI_Q30) begin
         half_red = turn_red + PI_Q30;
      end else begin
         half_red = turn_red;
         flip     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ps2_valid_ff <= 1'b0;
      end else if (adv) begin
         ps2_valid_ff <= ps1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ps2_data_ff.x    <= GAIN_Q30;
         ps2_data_ff.y    <= '0;
         ps2_data_ff.z    <= half_red[CZ_W-1:0];
         ps2_data_ff.flip <= flip;
         ps2_data_ff.info <= ps1_info_ff;
      end
   end

   // ---------------- cordic cell chain ----------------
   logic       cor_v [0:CORDIC_STAGES];
   cordic_type cor_d [0:CORDIC_STAGES];

   assign cor_v[0] = ps2_valid_ff;
   assign cor_d[0] = ps2_data_ff;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      rsmg_cordic_cell #(
         .STAGE (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (cor_v[g]),
         .in_data   (cor_d[g]),
         .out_valid (cor_v[g+1]),
         .out_data  (cor_d[g+1])
      );
   end

   // ---------------- radius scaling ----------------
   logic                     s1_valid_ff;
   logic signed [PROD_W-1:0] s1_pox_ff;
   logic signed [PROD_W-1:0] s1_poy_ff;
   logic signed [PROD_W-1:0] s1_pix_ff;
   logic signed [PROD_W-1:0] s1_piy_ff;
   info_type                 s1_info_ff;
   logic signed [CZ_W-1:0]   neg_sin;
   logic signed [CZ_W-1:0]   cosv;
   logic signed [PROD_W-1:0] r_out;
   logic signed [PROD_W-1:0] r_in;

   always_comb begin
      neg_sin = cor_d[CORDIC_STAGES].flip ? cor_d[CORDIC_STAGES].y : -cor_d[CORDIC_STAGES].y;
      cosv    = cor_d[CORDIC_STAGES].flip ? -cor_d[CORDIC_STAGES].x : cor_d[CORDIC_STAGES].x;
      r_out   = $signed(PROD_W'(outer_radius_ff));
      r_in    = $signed(PROD_W'(inner_radius_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= cor_v[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_pox_ff  <= PROD_W'(neg_sin) * r_out;
         s1_poy_ff  <= PROD_W'(cosv) * r_out;
         s1_pix_ff  <= PROD_W'(neg_sin) * r_in;
         s1_piy_ff  <= PROD_W'(cosv) * r_in;
         s1_info_ff <= cor_d[CORDIC_STAGES].info;
      end
   end

   // round half up to Q8.8 and clamp
   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      t = (p + ROUND_BIAS) >>> 30;
      if (t > POS_MAX) begin
         sat_pos = POS_MAX[POS_W-1:0];
      end else if (t < POS_MIN) begin
         sat_pos = POS_MIN[POS_W-1:0];
      end else begin
         sat_pos = t[POS_W-1:0];
      end
   endfunction

   logic        s2_valid_ff;
   pos_set_type s2_pos_ff;
   info_type    s2_info_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_pos_ff.ox <= sat_pos(s1_pox_ff);
         s2_pos_ff.oy <= sat_pos(s1_poy_ff);
         s2_pos_ff.ix <= sat_pos(s1_pix_ff);
         s2_pos_ff.iy <= sat_pos(s1_piy_ff);
         s2_info_ff   <= s1_info_ff;
      end
   end

   // ---------------- collector and record emitter ----------------
   logic             slot0_valid_ff;
   pos_set_type      slot0_pos_ff;
   logic [TEX_W-1:0] slot0_ratio_ff;

   logic             buf_valid_ff;
   pos_set_type      buf_pos0_ff;
   pos_set_type      buf_pos1_ff;
   logic [TEX_W-1:0] buf_ratio0_ff;
   logic [TEX_W-1:0] buf_ratio1_ff;
   logic [VTX_W-1:0] buf_base_ff;

   rec_state_type    rec_ff;
   rec_state_type    rec_in;

   logic             rsp_take;
   logic             buf_free;
   logic             col_take;
   logic             load_buf;

   assign rsp_take = buf_valid_ff && rsp_ch.ready;
   assign buf_free = !buf_valid_ff || (rsp_take && (rec_ff == REC_TRI1));
   // the first job only fills the holding slot, the second moves the pair out
   assign col_take = !s2_info_ff.j || buf_free;
   assign adv      = !s2_valid_ff || col_take;
   assign load_buf = s2_valid_ff && s2_info_ff.j && buf_free;

   always_comb begin
      case (rec_ff)
         REC_OUT0: rec_in = REC_OUT1;
         REC_OUT1: rec_in = REC_IN0;
         REC_IN0:  rec_in = REC_IN1;
         REC_IN1:  rec_in = REC_TRI0;
         REC_TRI0: rec_in = REC_TRI1;
         REC_TRI1: rec_in = REC_OUT0;
         default:  rec_in = REC_OUT0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot0_valid_ff <= 1'b0;
         buf_valid_ff   <= 1'b0;
         rec_ff         <= REC_OUT0;
      end else begin
         if (s2_valid_ff && adv) begin
            slot0_valid_ff <= !s2_info_ff.j;
         end
         if (load_buf) begin
            buf_valid_ff <= 1'b1;
            rec_ff       <= REC_OUT0;
         end else if (rsp_take) begin
            rec_ff <= rec_in;
            if (rec_ff == REC_TRI1) begin
               buf_valid_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && !s2_info_ff.j) begin
         slot0_pos_ff   <= s2_pos_ff;
         slot0_ratio_ff <= s2_info_ff.ratio;
      end
      if (load_buf) begin
         buf_pos0_ff   <= slot0_pos_ff;
         buf_ratio0_ff <= slot0_ratio_ff;
         buf_pos1_ff   <= s2_pos_ff;
         buf_ratio1_ff <= s2_info_ff.ratio;
         buf_base_ff   <= s2_info_ff.base;
      end
   end

   // output word select
   assign rsp_ch.valid = buf_valid_ff;

   always_comb begin
      rsp_ch.record_kind     = KIND_VERTEX;
      rsp_ch.pos_x           = '0;
      rsp_ch.pos_y           = '0;
      rsp_ch.tex_u           = '0;
      rsp_ch.tex_v           = '0;
      rsp_ch.vertex_color    = '0;
      rsp_ch.tri_first       = '0;
      rsp_ch.tri_second      = '0;
      rsp_ch.tri_third       = '0;
      rsp_ch.last_of_segment = 1'b0;
      case (rec_ff)
         REC_OUT0: begin
            rsp_ch.pos_x        = buf_pos0_ff.ox;
            rsp_ch.pos_y        = buf_pos0_ff.oy;
            rsp_ch.tex_u        = buf_ratio0_ff;
            rsp_ch.vertex_color = outer_color_ff;
         end
         REC_OUT1: begin
            rsp_ch.pos_x        = buf_pos1_ff.ox;
            rsp_ch.pos_y        = buf_pos1_ff.oy;
            rsp_ch.tex_u        = buf_ratio1_ff;
            rsp_ch.vertex_color = outer_color_ff;
         end
         REC_IN0: begin
            rsp_ch.pos_x        = buf_pos0_ff.ix;
            rsp_ch.pos_y        = buf_pos0_ff.iy;
            rsp_ch.tex_u        = buf_ratio0_ff;
            rsp_ch.tex_v        = TEX_V_INNER;
            rsp_ch.vertex_color = inner_color_ff;
         end
         REC_IN1: begin
            rsp_ch.pos_x        = buf_pos1_ff.ix;
            rsp_ch.pos_y        = buf_pos1_ff.iy;
            rsp_ch.tex_u        = buf_ratio1_ff;
            rsp_ch.tex_v        = TEX_V_INNER;
            rsp_ch.vertex_color = inner_color_ff;
         end
         REC_TRI0: begin
            rsp_ch.record_kind = KIND_TRIANGLE;
            rsp_ch.tri_first   = buf_base_ff + VTX_W'(2);
            rsp_ch.tri_second  = buf_base_ff;
            rsp_ch.tri_third   = buf_base_ff + VTX_W'(1);
         end
         REC_TRI1: begin
            rsp_ch.record_kind     = KIND_TRIANGLE;
            rsp_ch.tri_first       = buf_base_ff + VTX_W'(2);
            rsp_ch.tri_second      = buf_base_ff + VTX_W'(1);
            rsp_ch.tri_third       = buf_base_ff + VTX_W'(3);
            rsp_ch.last_of_segment = 1'b1;
         end
         default: ;
      endcase
   end

   // ---------------- checks ----------------
   a_slot0_free: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s2_info_ff.j && adv) |-> !slot0_valid_ff)
      else $error("first job overwrote a held first job");

   a_slot0_pair: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_info_ff.j && adv) |-> slot0_valid_ff)
      else $error("second job arrived without its first job");

   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      (buf_valid_ff && !rsp_ch.ready) |=> (buf_valid_ff && $stable(rec_ff)))
      else $error("emitter moved while the response was stalled");

   a_issue_start: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (hold_valid_ff && !hold_j_ff))
      else $error("accepted segment did not start with its first job");

endmodule

// ===== verif/rsmg_tb_ifs.sv =====
// note: the channel interfaces come from the rtl file rsmg_ifs.sv, this file holds tb helper types
package rsmg_tb_pkg;
   import rsmg_pkg::*;

   // one expected output word
   typedef struct {
      logic                    kind;
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
      logic [TEX_W-1:0]        u;
      logic [TEX_W-1:0]        v;
      logic [COLOR_W-1:0]      col;
      logic [VTX_W-1:0]        t1;
      logic [VTX_W-1:0]        t2;
      logic [VTX_W-1:0]        t3;
      logic                    last;
   } record_type;
endpackage

// ===== verif/tb_ring_sector_mesh_generator.sv =====
// testbench of the ring sector mesh generator: directed table plus random segments, scoreboarded
module tb_ring_sector_mesh_generator;
   timeunit 1ns;
   timeprecision 1ps;
   import rsmg_pkg::*;
   import rsmg_tb_pkg::*;

   logic clock;
   logic reset;

   rsmg_req_if req_ch();
   rsmg_rsp_if rsp_ch();
   rsmg_csr_if csr_ch();

   ring_sector_mesh_generator u_top (
      .clock(clock), .reset(reset),
      .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source), .csr_ch(csr_ch.sink)
   );

   // shadow of the block registers
   logic [RAD_W-1:0]   sh_inner_r, sh_outer_r;
   logic [CNT_W-1:0]   sh_count;
   logic [ANGLE_W-1:0] sh_start, sh_end;
   logic [COLOR_W-1:0] sh_inner_c, sh_outer_c;
   logic [VTX_W-1:0]   sh_base;

   record_type pending_records[$];
   int  mismatch_cnt;
   int  word_cnt;
   int  segment_cnt;
   int  hold_cycles;      // long receiver hold-off, counted by the sink process
   bit  quiet_stretch;    // no random idling while set

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("FAIL");
      $finish;
   end

   function automatic longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
   endfunction

   function automatic logic [30:0] atan_table(int k);
      logic [30:0] t[24] = '{31'h3243F6A8, 31'h1DAC6705, 31'h0FADBAFC, 31'h07F56EA6,
         31'h03FEAB76, 31'h01FFD55B, 31'h00FFFAAA, 31'h007FFF55, 31'h003FFFEA,
         31'h001FFFFD, 31'h000FFFFF, 31'h0007FFFF, 31'h0003FFFF, 31'h0001FFFF,
         31'h0000FFFF, 31'h00007FFF, 31'h00003FFF, 31'h00001FFF, 31'h00000FFF,
         31'h000007FF, 31'h000003FF, 31'h000001FF, 31'h000000FF, 31'h0000007F};
      return t[k];
   endfunction

   // cordic rotation, angle q4.30 in, sine and cosine q30 out
   task automatic rotate(input longint a, output longint s, output longint c);
      longint x, y, z, nx, xs, ys;
      bit flip;
      x = 652032874; y = 0; flip = 0;
      while (a > 64'sd3373259426) a -= 64'sd6746518852;
      while (a < -64'sd3373259426) a += 64'sd6746518852;
      if (a > 64'sd1686629713) begin
         a -= 64'sd3373259426; flip = 1;
      end else if (a < -64'sd1686629713) begin
         a += 64'sd3373259426; flip = 1;
      end
      z = a;
      for (int k = 0; k < CORDIC_STAGES_DEF; k++) begin
         xs = x >>> k;
         ys = y >>> k;
         if (z >= 0) begin
            nx = x - ys; y = y + xs; z -= longint'(atan_table(k));
         end else begin
            nx = x + ys; y = y - xs; z += longint'(atan_table(k));
         end
         x = nx;
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endtask

   function automatic logic signed [POS_W-1:0] scale(longint v, logic [RAD_W-1:0] r);
      longint p;
      p = floor_div(v * longint'(r) + (64'sd1 <<< 29), 64'sd1 <<< 30);
      if (p > 65535) p = 65535;
      if (p < -65536) p = -65536;
      return p[POS_W-1:0];
   endfunction

   // append one expected word at the tail
   function automatic void queue_record(record_type rec);
      pending_records.insert(pending_records.size(), rec);
   endfunction

   // expected six words of one segment
   task automatic predict_segment(input logic [SEG_W-1:0] seg);
      longint n, i, st, span, ang, ratio[2], sn[2], cs[2];
      logic [VTX_W-1:0] base;
      record_type rec;
      n = sh_count;
      if (n < 1) n = 1;
      if (n > MAX_SEGMENTS_DEF) n = MAX_SEGMENTS_DEF;
      i = seg;
      if (i >= n) i = n - 1;
      st = longint'($signed(sh_start));
      span = longint'($signed(sh_end)) - st;
      for (int j = 0; j < 2; j++) begin
         ang = st * 262144 + floor_div(2 * (i + j) * span * 262144 + n, 2 * n);
         ratio[j] = floor_div(2 * (i + j) * 65536 + n, 2 * n);
         rotate(ang, sn[j], cs[j]);
      end
      for (int w = 0; w < 4; w++) begin
         rec = '{default: '0};
         rec.kind = KIND_VERTEX;
         rec.px = scale(-sn[w % 2], (w < 2) ? sh_outer_r : sh_inner_r);
         rec.py = scale(cs[w % 2], (w < 2) ? sh_outer_r : sh_inner_r);
         rec.u = ratio[w % 2][TEX_W-1:0];
         rec.v = (w < 2) ? '0 : TEX_V_INNER;
         rec.col = (w < 2) ? sh_outer_c : sh_inner_c;
         queue_record(rec);
      end
      base = sh_base + VTX_W'(4 * i);
      rec = '{default: '0};
      rec.kind = KIND_TRIANGLE;
      rec.t1 = base + VTX_W'(2); rec.t2 = base; rec.t3 = base + VTX_W'(1);
      queue_record(rec);
      rec.t2 = base + VTX_W'(1); rec.t3 = base + VTX_W'(3); rec.last = 1'b1;
      queue_record(rec);
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         REG_INNER_RADIUS:  sh_inner_r = val[RAD_W-1:0];
         REG_OUTER_RADIUS:  sh_outer_r = val[RAD_W-1:0];
         REG_SEGMENT_COUNT: sh_count   = val[CNT_W-1:0];
         REG_START_ANGLE:   sh_start   = val[ANGLE_W-1:0];
         REG_END_ANGLE:     sh_end     = val[ANGLE_W-1:0];
         REG_INNER_COLOR:   sh_inner_c = val;
         REG_OUTER_COLOR:   sh_outer_c = val;
         REG_BASE_VERTEX:   sh_base    = val[VTX_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   // unlisted index, must be dropped by the block
   task automatic write_unknown(input logic [CSR_IDX_W-1:0] idx);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= $urandom;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   // valid stays up after the accept; the next send or drain takes it over
   task automatic send_segment(input logic [SEG_W-1:0] seg);
      if (!quiet_stretch) begin
         while ($urandom_range(99) < 6) begin
            req_ch.valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_ch.valid <= 1'b1;
      req_ch.segment_index <= seg;
      do @(posedge clock); while (!req_ch.ready);
      predict_segment(seg);
      segment_cnt++;
      @(negedge clock);
   endtask

   // wait until every expected word is back, then let the pipe settle
   task automatic drain;
      int guard;
      guard = 0;
      req_ch.valid <= 1'b0;
      while (pending_records.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      repeat (120) @(negedge clock);
   endtask

   // response sink with random stalls and one long hold-off
   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_ch.ready <= quiet_stretch ? 1'b1 : ($urandom_range(99) >= 6);
         end
         @(negedge clock);
      end
   end

   // scoreboard on accepted words
   always @(posedge clock) begin
      record_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         word_cnt++;
         if (pending_records.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) $display("unexpected word at %0t", $realtime);
         end else begin
            e = pending_records.pop_front();
            if (rsp_ch.record_kind !== e.kind || rsp_ch.pos_x !== e.px ||
                rsp_ch.pos_y !== e.py || rsp_ch.tex_u !== e.u || rsp_ch.tex_v !== e.v ||
                rsp_ch.vertex_color !== e.col || rsp_ch.tri_first !== e.t1 ||
                rsp_ch.tri_second !== e.t2 || rsp_ch.tri_third !== e.t3 ||
                rsp_ch.last_of_segment !== e.last) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("mismatch at %0t: exp k%0d x%0d y%0d u%0d v%0d c%h t%0d,%0d,%0d l%0d",
                     $realtime, e.kind, e.px, e.py, e.u, e.v, e.col, e.t1, e.t2, e.t3,
                     e.last, "\n   got k%0d x%0d y%0d u%0d v%0d c%h t%0d,%0d,%0d l%0d",
                     rsp_ch.record_kind, rsp_ch.pos_x, rsp_ch.pos_y, rsp_ch.tex_u,
                     rsp_ch.tex_v, rsp_ch.vertex_color, rsp_ch.tri_first,
                     rsp_ch.tri_second, rsp_ch.tri_third, rsp_ch.last_of_segment);
            end
         end
      end
   end

   typedef struct {
      logic [SEG_W-1:0] seg;
      bit               typed;     // expected first triangle index given in the row
      logic [VTX_W-1:0] tri_a;     // first index of the first triangle
   } seg_row_type;

   // main stimulus
   initial begin
      seg_row_type table_rows[$];
      int          tri_pos;
      logic [12:0] cnt_pick;
      mismatch_cnt = 0; word_cnt = 0; segment_cnt = 0;
      hold_cycles = 0; quiet_stretch = 0;
      req_ch.valid = 1'b0; req_ch.segment_index = '0;
      csr_ch.valid = 1'b0; csr_ch.index = '0; csr_ch.data = '0;
      sh_inner_r = 128; sh_outer_r = 256; sh_count = 32; sh_start = 0; sh_end = 25736;
      sh_inner_c = 32'hFFFF_FFFF; sh_outer_c = 32'hFFFF_FFFF; sh_base = 0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: defaults after reset, index extremes and saturation
      table_rows = '{'{12'd0, 1, 24'd2}, '{12'd31, 1, 24'd126}, '{12'd32, 1, 24'd126},
                     '{12'd4095, 1, 24'd126}, '{12'd7, 0, 0}, '{12'd16, 0, 0}};
      foreach (table_rows[r]) begin
         send_segment(table_rows[r].seg);
         // triangle first index typed from the row, the rest via predictor
         tri_pos = pending_records.size() - 2;
         if (table_rows[r].typed && pending_records[tri_pos].t1 !== table_rows[r].tri_a) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) $display("directed row %0d: triangle base off", r);
         end
      end
      drain();

      // extremes of every register, unknown index dropped
      write_reg(REG_INNER_RADIUS, 32'h0000_FFFF);
      write_reg(REG_OUTER_RADIUS, 32'h0000_0000);
      write_reg(REG_SEGMENT_COUNT, 32'd0);          // acts as one segment
      write_reg(REG_START_ANGLE, 32'h0000_8000);
      write_reg(REG_END_ANGLE, 32'h0000_7FFF);
      write_reg(REG_INNER_COLOR, 32'h0000_0000);
      write_reg(REG_OUTER_COLOR, 32'hA5A5_5A5A);
      write_reg(REG_BASE_VERTEX, 32'hFFFF_FFFE);    // triangle indices wrap
      write_unknown(8'd8);
      write_unknown(8'hFF);
      send_segment(12'd0); send_segment(12'hFFF);
      drain();
      write_reg(REG_SEGMENT_COUNT, 32'h1FFF);       // above max, clamps to 4096
      write_reg(REG_START_ANGLE, 32'h0000_7FFF);
      write_reg(REG_END_ANGLE, 32'h0000_8000);
      send_segment(12'd0); send_segment(12'd2048); send_segment(12'd4095);
      drain();
      write_reg(REG_SEGMENT_COUNT, 32'd4096);
      write_reg(REG_OUTER_RADIUS, 32'hFFFF);
      send_segment(12'd1024); send_segment(12'd3071); send_segment(12'd4095);
      drain();

      // long receiver hold-off while the sender keeps offering, enough to fill the chain
      hold_cycles = 300;
      for (int k = 0; k < 48; k++) send_segment(SEG_W'($urandom));
      drain();

      // random phases with fresh register settings
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(REG_INNER_RADIUS, $urandom);
         write_reg(REG_OUTER_RADIUS, $urandom);
         cnt_pick = (ph % 3 == 0) ? 13'($urandom) : 13'($urandom_range(64, 1));
         write_reg(REG_SEGMENT_COUNT, CSR_DATA_W'(cnt_pick));
         write_reg(REG_START_ANGLE, $urandom);
         write_reg(REG_END_ANGLE, $urandom);
         write_reg(REG_INNER_COLOR, $urandom);
         write_reg(REG_OUTER_COLOR, $urandom);
         write_reg(REG_BASE_VERTEX, $urandom);
         quiet_stretch = (ph == 3);
         for (int k = 0; k < 18; k++)
            send_segment((k % 5 == 0) ? 12'($urandom) : 12'($urandom_range(cnt_pick, 0)));
         quiet_stretch = 0;
         drain();
      end

      $display("covered %0d segments, %0d words, register extremes, index clamps and stalls",
               segment_cnt, word_cnt);
      if (mismatch_cnt == 0 && pending_records.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
